// File: rtl/life_grid_generation_step_unit_defines.svh
// Assertion macros shared by the life grid RTL.
`ifndef LIFE_GRID_GENERATION_STEP_UNIT_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lgs_pkg.sv
// Shared types and constants of the life grid step unit.
package lgs_pkg;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       set;
    logic [5:0] row;
    logic [5:0] col;
    logic       value;
  } cell_ctrl_t;

endpackage

// File: rtl/lgs_row_cell.sv
// One grid row: a link of the row chain with local set and clear.
module lgs_row_cell #(
  parameter int WIDTH = 64,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lgs_pkg::cell_ctrl_t ctrl,
  input  logic [WIDTH-1:0]    shift_in,
  output logic [WIDTH-1:0]    row_q
);
  import lgs_pkg::*;

  localparam int IW = (INDEX > 63) ? 9 : 6;

  logic [WIDTH-1:0] row_r;
  logic [WIDTH-1:0] row_nxt;
  logic             hit;

  assign hit = ctrl.set && (IW'(ctrl.row) == IW'(INDEX));

  always_comb begin
    row_nxt = row_r;
    if (ctrl.clear) begin
      row_nxt = '0;
    end else if (ctrl.shift) begin
      row_nxt = shift_in;
    end else if (hit) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (ctrl.col == 6'(b)) begin
          row_nxt[b] = ctrl.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

// File: rtl/lgs_rule.sv
// B3/S23 rule applied to every column of one row from a three-row window.
module lgs_rule #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] up,
  input  logic [WIDTH-1:0] mid,
  input  logic [WIDTH-1:0] dn,
  input  logic [WIDTH-1:0] mask,
  output logic [WIDTH-1:0] nrow
);
  import lgs_pkg::*;

  logic [WIDTH+1:0] up_x;
  logic [WIDTH+1:0] mid_x;
  logic [WIDTH+1:0] dn_x;

  assign up_x  = {1'b0, up, 1'b0};
  assign mid_x = {1'b0, mid, 1'b0};
  assign dn_x  = {1'b0, dn, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < WIDTH; c++) begin
      n = {3'b0, up_x[c]} + {3'b0, up_x[c+1]} + {3'b0, up_x[c+2]}
        + {3'b0, mid_x[c]} + {3'b0, mid_x[c+2]}
        + {3'b0, dn_x[c]} + {3'b0, dn_x[c+1]} + {3'b0, dn_x[c+2]};
      nrow[c] = mask[c] && ((n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && mid[c]));
    end
  end

endmodule

// File: rtl/life_grid_generation_step_unit.sv
// Top level of the life grid step unit: register port, command control, row chain.
//
// The grid lives in a chain of MAX_ROWS row cells. Set and clear requests
// are written into the row cells as they are accepted, and a new request is
// taken the next cycle. A step request rotates the chain once around, one
// row per cycle while out_ready does not hold a result back. Each rotation
// cycle runs the rule over the window of previous, head and following row and
// writes the new row to the tail; rows in use are reported in order, top row
// first, one result per row, with last marking the final one. Rows beyond the
// height in use and columns beyond the width in use are cleared by a step and
// read as zero.
// Configuration: byte address 0 is the width, 4 the height (7 bits each,
// reset 64). Write them only while no request is in progress.
module life_grid_generation_step_unit #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_col,
  input  logic [5:0]  in_row,
  input  logic        in_cell_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_row_index,
  output logic [63:0] out_row_bits,
  output logic [63:0] out_changed_bits,
  output logic        out_last
);
  import lgs_pkg::*;

  localparam int ROW_LIM = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int CMP_W   = (ROW_W > 7) ? ROW_W : 7;

  logic [6:0] cols_cfg_r;
  logic [6:0] rows_cfg_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= 7'd64;
      rows_cfg_r <= 7'd64;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COLS: cols_cfg_r <= pwdata[6:0];
        REG_ROWS: rows_cfg_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLS: prdata = {25'b0, cols_cfg_r};
      REG_ROWS: prdata = {25'b0, rows_cfg_r};
      default:  prdata = '0;
    endcase
  end

  logic [6:0]          cols_eff;
  logic [6:0]          rows_eff;
  logic [CMP_W-1:0]    rows_ext;
  logic [MAX_COLS-1:0] mask;

  always_comb begin
    if (cols_cfg_r == 7'd0) begin
      cols_eff = 7'd1;
    end else if (cols_cfg_r > 7'(MAX_COLS)) begin
      cols_eff = 7'(MAX_COLS);
    end else begin
      cols_eff = cols_cfg_r;
    end
    if (rows_cfg_r == 7'd0) begin
      rows_eff = 7'd1;
    end else if (rows_cfg_r > 7'(ROW_LIM)) begin
      rows_eff = 7'(ROW_LIM);
    end else begin
      rows_eff = rows_cfg_r;
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      mask[c] = (7'(c) < cols_eff);
    end
  end

  assign rows_ext = CMP_W'(rows_eff);

  state_t           state_r;
  state_t           state_nxt;
  logic [ROW_W-1:0] k_r;
  logic [ROW_W-1:0] k_nxt;
  logic [CMP_W-1:0] k_ext;
  logic             in_acc;
  logic             stepping;
  logic             row_live;
  logic             adv;
  logic             k_end;

  assign in_acc   = in_valid && in_ready;
  assign k_ext    = CMP_W'(k_r);
  assign row_live = (k_ext < rows_ext);
  assign k_end    = (k_r == ROW_W'(MAX_ROWS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && (in_cmd == CMD_STEP)) state_nxt = ST_STEP;
      ST_STEP: if (adv && k_end) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    stepping = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_STEP: stepping = 1'b1;
      default: ;
    endcase
  end

  assign adv = stepping && (!row_live || !out_valid || out_ready);

  always_comb begin
    k_nxt = k_r;
    if (in_acc) begin
      k_nxt = '0;
    end else if (adv) begin
      k_nxt = k_end ? '0 : k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  cell_ctrl_t          ctrl;
  logic [MAX_COLS-1:0] grid_q [MAX_ROWS];
  logic [MAX_COLS-1:0] prev_r;
  logic [MAX_COLS-1:0] up;
  logic [MAX_COLS-1:0] mid;
  logic [MAX_COLS-1:0] dn;
  logic [MAX_COLS-1:0] nrow;
  logic [MAX_COLS-1:0] wb_row;

  assign ctrl.shift = adv;
  assign ctrl.clear = in_acc && (in_cmd == CMD_CLEAR);
  assign ctrl.set   = in_acc && (in_cmd == CMD_SET) && (7'(in_col) < cols_eff)
                      && (7'(in_row) < rows_eff);
  assign ctrl.row   = in_row;
  assign ctrl.col   = in_col;
  assign ctrl.value = in_cell_value;

  assign up     = prev_r;
  assign mid    = grid_q[0] & mask;
  assign dn     = (k_ext + 1'b1 < rows_ext) ? (grid_q[1] & mask) : '0;
  assign wb_row = row_live ? nrow : '0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ROWS; gi++) begin : g_row
      if (gi == MAX_ROWS - 1) begin : g_tail
        lgs_row_cell #(.WIDTH(MAX_COLS), .INDEX(gi)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ctrl     (ctrl),
          .shift_in (wb_row),
          .row_q    (grid_q[gi])
        );
      end else begin : g_link
        lgs_row_cell #(.WIDTH(MAX_COLS), .INDEX(gi)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ctrl     (ctrl),
          .shift_in (grid_q[gi+1]),
          .row_q    (grid_q[gi])
        );
      end
    end
  endgenerate

  lgs_rule #(.WIDTH(MAX_COLS)) u_rule (
    .up   (up),
    .mid  (mid),
    .dn   (dn),
    .mask (mask),
    .nrow (nrow)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_r <= '0;
    end else if (adv) begin
      prev_r <= mid;
    end
  end

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_load;
  logic [5:0]          row_index_r;
  logic [MAX_COLS-1:0] row_bits_r;
  logic [MAX_COLS-1:0] changed_r;
  logic                last_r;
  logic [CMP_W-1:0]    last_ext;

  assign out_load = adv && row_live;
  assign last_ext = rows_ext - 1'b1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_index_r <= k_ext[5:0];
      row_bits_r  <= nrow;
      changed_r   <= nrow ^ mid;
      last_r      <= (k_ext == last_ext);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = row_index_r;
  assign out_row_bits     = 64'(row_bits_r);
  assign out_changed_bits = 64'(changed_r);
  assign out_last         = last_r;

`include "life_grid_generation_step_unit_defines.svh"

  `ASSERT_NEXT(a_step_start, clk, rst_n, in_acc && (in_cmd == CMD_STEP), (state_r == ST_STEP) && (k_r == '0))
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, stepping && row_live && out_valid && !out_ready, $stable(grid_q[0]) && $stable(k_r))
  `ASSERT_IMPLY(a_last_row, clk, rst_n, out_valid && out_last, out_row_index == last_ext[5:0])

endmodule
